// File: rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types, character codes and the line-comment stage function of the
// comment stripper.
// ----------------------------------------------------------------------------
package ccs_pkg;

   localparam int LINE_BITS   = 16;
   localparam int COLUMN_BITS = 16;
   localparam int POS_BITS    = 16;      // width of the position fields on the result side
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

   localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
   localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_QUOTE   = 8'h22;

   typedef struct packed {
      logic [7:0]             ch;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] col;
   } tagged_type;

   typedef struct packed {
      logic                 in_string;
      logic                 in_comment;
      logic [LINE_BITS-1:0] start_line;
      logic                 pend_valid;
      tagged_type           pend;
   } line_state_type;

   typedef struct packed {
      line_state_type s;
      logic [1:0]     n;
      tagged_type     e0;
      tagged_type     e1;
   } line_out_type;

   // One queue entry: all results of one accepted byte.
   typedef struct packed {
      logic [1:0]           n;       // number of results, 1 to 3
      logic                 marker;  // end marker with no character
      logic                 fin;
      tagged_type [2:0]     item;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // Line-comment stage: takes one tagged character, returns up to two
   // characters to pass on.
   function automatic line_out_type line_stage(line_state_type s, tagged_type y);
      line_out_type r;
      logic         skip;
      r.s  = s;
      r.n  = 2'd0;
      r.e0 = y;
      r.e1 = y;
      skip = 1'b0;
      if (s.in_comment) begin
         if (y.line > s.start_line) begin
            r.s.in_comment = 1'b0;
         end else begin
            skip = 1'b1;
         end
      end
      if (!skip) begin
         if (r.s.in_string) begin
            r.n  = 2'd1;
            r.e0 = y;
            if (y.ch == CH_QUOTE) begin
               r.s.in_string = 1'b0;
            end
         end else if (r.s.pend_valid && y.ch == CH_SLASH) begin
            r.s.pend_valid = 1'b0;
            r.s.in_comment = 1'b1;
            r.s.start_line = y.line;
         end else begin
            if (r.s.pend_valid) begin
               r.e0           = r.s.pend;
               r.n            = 2'd1;
               r.s.pend_valid = 1'b0;
            end
            if (y.ch == CH_SLASH) begin
               r.s.pend_valid = 1'b1;
               r.s.pend       = y;
            end else begin
               if (r.n == 2'd1) begin
                  r.e1 = y;
               end else begin
                  r.e0 = y;
               end
               r.n = r.n + 2'd1;
               if (y.ch == CH_QUOTE) begin
                  r.s.in_string = 1'b1;
               end
            end
         end
      end
      return r;
   endfunction

   function automatic logic [POS_BITS-1:0] line_field(logic [LINE_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[POS_BITS-1:0];
   endfunction

   function automatic logic [POS_BITS-1:0] column_field(logic [COLUMN_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[POS_BITS-1:0];
   endfunction

endpackage

// File: rtl/comment_stripper_with_position.sv
// ----------------------------------------------------------------------------
// comment_stripper_with_position
// Strips block and line comments from a byte stream and tags every kept
// character with its line and column.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  req      in   req_tvalid/req_tready   tdata: ch, tlast: final_byte
//  rsp      out  rsp_tvalid/rsp_tready   tdata: out_char, line_no, column_no;
//                                        tuser: has_char, text_done; tlast: last_of_run
//
//  One byte is taken per cycle while the queue is not full; a byte that yields
//  k results holds the output side until all k have left, and the 4-entry queue between front and back absorbs that.
//  A result is registered in a queue entry and then in the output register.
//  Reset is synchronous and active high; it empties the queue and clears control state.
//  req_tready drops only while the queue is full; rsp stalls back up into it.
// ----------------------------------------------------------------------------
module comment_stripper_with_position (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] ch
   input  logic        req_tlast,    // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [7:0] out_char, [23:8] line_no, [39:24] column_no
   output logic [1:0]  rsp_tuser,    // [0] has_char, [1] text_done
   output logic        rsp_tlast     // last_of_run
);

   ccs_pkg::fifo_status_type fifo_status;
   ccs_pkg::entry_type       push_entry;
   ccs_pkg::entry_type       head;
   logic                     push;
   logic                     pop;

   ccs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .fifo_status (fifo_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   ccs_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (fifo_status)
   );

   ccs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .fifo_status (fifo_status),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_status.full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_status.empty)
      else $error("queue pop while empty");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tlast)
      else $error("text_done on a result that is not last of its run");

   a_marker_ends_text: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tuser[1] && rsp_tlast && rsp_tdata == '0))
      else $error("end marker without text_done");

endmodule

// File: rtl/ccs_front.sv
// ----------------------------------------------------------------------------
// ccs_front
// Accepts source bytes, tracks line and column, runs both comment stages and
// pushes the results of each byte as one queue entry.
// ----------------------------------------------------------------------------
module ccs_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] ch
   input  logic                     req_tlast,   // final_byte
   input  ccs_pkg::fifo_status_type fifo_status,
   output logic                     push,
   output ccs_pkg::entry_type       push_entry
);

   logic [ccs_pkg::LINE_BITS-1:0]   line_ff, line_in;
   logic [ccs_pkg::COLUMN_BITS-1:0] col_ff, col_in;
   logic                            bstr_ff, bstr_in;
   logic                            bcom_ff, bcom_in;
   logic                            star_ff, star_in;
   logic                            bpv_ff, bpv_in;
   ccs_pkg::tagged_type             bpend_ff, bpend_in;
   ccs_pkg::line_state_type         ls_ff, ls_in;

   logic                            accept;
   ccs_pkg::tagged_type             slot [7];
   logic [6:0]                      slot_v;
   ccs_pkg::tagged_type             items [3];
   logic [2:0]                      cnt;

   assign req_tready = !fifo_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      ccs_pkg::tagged_type     x;
      ccs_pkg::line_out_type   ro;
      ccs_pkg::line_state_type ls;
      logic                    bstr, bcom, star, bpv;
      ccs_pkg::tagged_type     bpend;

      ls     = ls_ff;
      bstr   = bstr_ff;
      bcom   = bcom_ff;
      star   = star_ff;
      bpv    = bpv_ff;
      bpend  = bpend_ff;
      x      = '{ch: req_tdata, line: line_ff, col: col_ff};
      ro     = '0;
      slot_v = '0;
      for (int k = 0; k < 7; k++) begin
         slot[k] = x;
      end

      line_in = line_ff;
      col_in  = col_ff;

      if (req_tdata == ccs_pkg::CH_NEWLINE) begin
         if (line_ff != ccs_pkg::LINE_MAX) begin
            line_in = line_ff + 1'b1;
         end
         col_in = '0;
      end else begin
         if (col_ff != ccs_pkg::COLUMN_MAX) begin
            col_in = col_ff + 1'b1;
         end
         if (bcom) begin
            if (star && req_tdata == ccs_pkg::CH_SLASH) begin
               bcom = 1'b0;
               star = 1'b0;
            end else begin
               star = (req_tdata == ccs_pkg::CH_STAR);
            end
         end else if (bstr) begin
            ro        = ccs_pkg::line_stage(ls, x);
            ls        = ro.s;
            slot[2]   = ro.e0;
            slot[3]   = ro.e1;
            slot_v[2] = (ro.n != 2'd0);
            slot_v[3] = (ro.n == 2'd2);
            if (req_tdata == ccs_pkg::CH_QUOTE) begin
               bstr = 1'b0;
            end
         end else if (bpv && req_tdata == ccs_pkg::CH_STAR) begin
            bpv  = 1'b0;
            bcom = 1'b1;
            star = 1'b0;
         end else begin
            if (bpv) begin
               bpv       = 1'b0;
               ro        = ccs_pkg::line_stage(ls, bpend);
               ls        = ro.s;
               slot[0]   = ro.e0;
               slot[1]   = ro.e1;
               slot_v[0] = (ro.n != 2'd0);
               slot_v[1] = (ro.n == 2'd2);
            end
            if (req_tdata == ccs_pkg::CH_SLASH) begin
               bpv   = 1'b1;
               bpend = x;
            end else begin
               ro        = ccs_pkg::line_stage(ls, x);
               ls        = ro.s;
               slot[2]   = ro.e0;
               slot[3]   = ro.e1;
               slot_v[2] = (ro.n != 2'd0);
               slot_v[3] = (ro.n == 2'd2);
               if (req_tdata == ccs_pkg::CH_QUOTE) begin
                  bstr = 1'b1;
               end
            end
         end
      end

      // flush both pending slashes on the final byte
      if (req_tlast) begin
         if (bpv) begin
            bpv       = 1'b0;
            ro        = ccs_pkg::line_stage(ls, bpend);
            ls        = ro.s;
            slot[4]   = ro.e0;
            slot[5]   = ro.e1;
            slot_v[4] = (ro.n != 2'd0);
            slot_v[5] = (ro.n == 2'd2);
         end
         if (ls.pend_valid) begin
            ls.pend_valid = 1'b0;
            slot[6]       = ls.pend;
            slot_v[6]     = 1'b1;
         end
      end

      ls_in    = ls;
      bstr_in  = bstr;
      bcom_in  = bcom;
      star_in  = star;
      bpv_in   = bpv;
      bpend_in = bpend;
   end

   // compact the slots, keep the first three
   always_comb begin
      cnt = 3'd0;
      for (int k = 0; k < 3; k++) begin
         items[k] = slot[0];
      end
      for (int k = 0; k < 7; k++) begin
         if (slot_v[k] && cnt < 3'd3) begin
            items[cnt[1:0]] = slot[k];
            cnt             = cnt + 3'd1;
         end
      end
   end

   always_comb begin
      push_entry.marker  = (cnt == 3'd0);
      push_entry.n       = (cnt == 3'd0) ? 2'd1 : cnt[1:0];
      push_entry.fin     = req_tlast;
      push_entry.item[0] = (cnt == 3'd0) ? '0 : items[0];
      push_entry.item[1] = items[1];
      push_entry.item[2] = items[2];
      push               = accept && (cnt != 3'd0 || req_tlast);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_tlast)) begin
         line_ff  <= '0;
         col_ff   <= '0;
         bstr_ff  <= 1'b0;
         bcom_ff  <= 1'b0;
         star_ff  <= 1'b0;
         bpv_ff   <= 1'b0;
         bpend_ff <= '0;
         ls_ff    <= '0;
      end else if (accept) begin
         line_ff  <= line_in;
         col_ff   <= col_in;
         bstr_ff  <= bstr_in;
         bcom_ff  <= bcom_in;
         star_ff  <= star_in;
         bpv_ff   <= bpv_in;
         bpend_ff <= bpend_in;
         ls_ff    <= ls_in;
      end
   end

endmodule

// File: rtl/ccs_fifo.sv
// ----------------------------------------------------------------------------
// ccs_fifo
// Short register queue of result entries between the front and back parts.
// ----------------------------------------------------------------------------
module ccs_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ccs_pkg::entry_type        push_entry,
   input  logic                      pop,
   output ccs_pkg::entry_type        head,
   output ccs_pkg::fifo_status_type  status
);

   ccs_pkg::entry_type              mem_ff [ccs_pkg::FIFO_DEPTH];
   logic [ccs_pkg::FIFO_AW-1:0]     wr_ff, wr_in;
   logic [ccs_pkg::FIFO_AW-1:0]     rd_ff, rd_in;
   logic [ccs_pkg::FIFO_AW:0]       cnt_ff, cnt_in;

   assign head         = mem_ff[rd_ff];
   assign status.full  = (cnt_ff == (ccs_pkg::FIFO_AW+1)'(ccs_pkg::FIFO_DEPTH));
   assign status.empty = (cnt_ff == '0);

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/ccs_back.sv
// ----------------------------------------------------------------------------
// ccs_back
// Walks the head queue entry one result at a time into the output register.
// ----------------------------------------------------------------------------
module ccs_back (
   input  logic                     clock,
   input  logic                     reset,
   input  ccs_pkg::entry_type       head,
   input  ccs_pkg::fifo_status_type fifo_status,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [39:0]              rsp_tdata,   // [7:0] out_char, [23:8] line_no,
                                                 // [39:24] column_no
   output logic [1:0]               rsp_tuser,   // [0] has_char, [1] text_done
   output logic                     rsp_tlast    // last_of_run
);

   logic                            valid_ff, valid_in;
   logic [1:0]                      idx_ff, idx_in;
   logic [39:0]                     data_ff;
   logic [1:0]                      user_ff;
   logic                            last_ff;

   logic                            load;
   logic                            is_last;
   ccs_pkg::tagged_type             cur;

   assign load    = !fifo_status.empty && (!valid_ff || rsp_tready);
   assign is_last = (idx_ff == head.n - 2'd1);
   assign cur     = head.item[idx_ff];
   assign pop     = load && is_last;

   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // hold the result until its transfer
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= {ccs_pkg::column_field(cur.col), ccs_pkg::line_field(cur.line), cur.ch};
         user_ff <= {head.fin && is_last, !head.marker};
         last_ff <= is_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule
